/* rtl/core/dmm_pkg.sv */
`default_nettype none
package dmm_pkg;

  localparam int OPC_W   = 2;
  localparam int IDX_W   = 6;
  localparam int VAL_W   = 32;
  localparam int CNT_W   = 7;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 4;
  localparam int EXP_W   = 12;
  localparam int WORD_W  = 64;

  localparam int DEF_MAX_DIM = 64;

  localparam logic [OPC_W-1:0] OP_LOAD_A  = 2'd0;
  localparam logic [OPC_W-1:0] OP_LOAD_B  = 2'd1;
  localparam logic [OPC_W-1:0] OP_COMPUTE = 2'd2;

  localparam logic [1:0] REG_ROW   = 2'd0;
  localparam logic [1:0] REG_COL   = 2'd1;
  localparam logic [1:0] REG_INNER = 2'd2;

  localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

  localparam logic [VAL_W-1:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [VAL_W-1:0] INF_BITS  = 32'h7F80_0000;

  // Unbiased exponent of the integer significand.
  function automatic logic signed [EXP_W-1:0] unb_exp(input logic [7:0] x);
    if (x != 8'd0) begin
      unb_exp = $signed({4'b0, x}) - 12'sd150;
    end else begin
      unb_exp = -12'sd149;
    end
  endfunction

  function automatic logic [23:0] sig_of(input logic [31:0] v);
    sig_of = {(v[30:23] != 8'd0), v[22:0]};
  endfunction

endpackage
`default_nettype wire

/* rtl/core/dmm_if.sv */
`default_nettype none
interface dmm_in_if;
  logic                        valid;
  logic                        ready;
  logic [dmm_pkg::OPC_W-1:0]   opcode;
  logic [dmm_pkg::IDX_W-1:0]   row_index;
  logic [dmm_pkg::IDX_W-1:0]   col_index;
  logic [dmm_pkg::VAL_W-1:0]   element_value;

  modport source (output valid, opcode, row_index, col_index, element_value, input ready);
  modport sink (input valid, opcode, row_index, col_index, element_value, output ready);
endinterface

interface dmm_out_if;
  logic                        valid;
  logic                        ready;
  logic [dmm_pkg::IDX_W-1:0]   out_row;
  logic [dmm_pkg::IDX_W-1:0]   out_col;
  logic [dmm_pkg::VAL_W-1:0]   product_value;
  logic                        row_done;

  modport source (output valid, out_row, out_col, product_value, row_done, input ready);
  modport sink (input valid, out_row, out_col, product_value, row_done, output ready);
endinterface
`default_nettype wire

/* rtl/core/dense_matrix_multiply_unit.sv */
`default_nettype none
// Single-precision matrix multiply C = A * B with A and B held in two on-chip
// stores of MAX_DIM x MAX_DIM words, loaded one element per transfer. A compute
// transfer names a row of C (one at or past row_count is dropped) and the block
// returns that row as col_count result transfers in column order, the last one
// flagged; a count of zero acts as one, one above MAX_DIM as MAX_DIM. Every
// element is a chain of inner_count IEEE fused multiply-adds with
// round-to-nearest-even, done by one shared datapath under a sequencer: a step
// where A or B is zero or any operand is infinite or NaN bypasses the multiply
// and add, any other step uses the shared normalizing shifter that moves 8 or 1
// bit per cycle. A row costs col_count * inner_count steps plus its result
// transfers; no new input is taken until the row is done. The stores are not
// cleared after reset; every element must be loaded before it is used.
module dense_matrix_multiply_unit #(
  parameter int MAX_DIM = dmm_pkg::DEF_MAX_DIM
) (
  input  logic                         clk,
  input  logic                         rst_n,
  dmm_in_if.sink                       in_ch,
  dmm_out_if.source                    out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [dmm_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [dmm_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [dmm_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW    = ($clog2(MAX_DIM + 1) > dmm_pkg::CNT_W) ?
                         $clog2(MAX_DIM + 1) : dmm_pkg::CNT_W;
  localparam logic [EW-1:0] MAXD = EW'(MAX_DIM);
  localparam int XW    = dmm_pkg::EXP_W;
  localparam int WW    = dmm_pkg::WORD_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_NPROD = 4'd3;
  localparam logic [3:0] S_NADD  = 4'd4;
  localparam logic [3:0] S_ALIGN = 4'd5;
  localparam logic [3:0] S_ADD   = 4'd6;
  localparam logic [3:0] S_NRES  = 4'd7;
  localparam logic [3:0] S_ROUND = 4'd8;
  localparam logic [3:0] S_NEXT  = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  function automatic logic [EW-1:0] eff(input logic [dmm_pkg::CNT_W-1:0] v);
    logic [EW-1:0] x;
    x = EW'(v);
    if (x == '0) begin
      eff = EW'(1);
    end else if (x > MAXD) begin
      eff = MAXD;
    end else begin
      eff = x;
    end
  endfunction

  logic [dmm_pkg::CNT_W-1:0] row_cnt_r, col_cnt_r, inner_cnt_r;
  logic [3:0]                state_r;
  logic [dmm_pkg::IDX_W-1:0] row_r;
  logic [IW-1:0]             i_r, j_r;
  logic [31:0]               acc_r;
  logic [31:0]               rda_r, rdb_r;
  logic [31:0]               mem_a [DEPTH];
  logic [31:0]               mem_b [DEPTH];

  logic [WW-1:0]             w_r, pm_r, big_r, small_r;
  logic signed [XW-1:0]      e_r, pe_r, ce_r, be_r;
  logic                      sp_r, sc_r, cz_r, bsign_r, sub_r;
  logic [23:0]               cm_r;

  logic [dmm_pkg::IDX_W-1:0] out_row_r, out_col_r;
  logic [31:0]               out_val_r;
  logic                      out_done_r;

  logic [EW-1:0] m_eff, n_eff, k_eff;
  assign m_eff = eff(row_cnt_r);
  assign n_eff = eff(col_cnt_r);
  assign k_eff = eff(inner_cnt_r);

  // Configuration port.
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite;

  always_comb begin
    unique case (cfg_paddr[3:2])
      dmm_pkg::REG_ROW:   cfg_prdata = 32'(row_cnt_r);
      dmm_pkg::REG_COL:   cfg_prdata = 32'(col_cnt_r);
      dmm_pkg::REG_INNER: cfg_prdata = 32'(inner_cnt_r);
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r   <= dmm_pkg::CNT_RESET;
      col_cnt_r   <= dmm_pkg::CNT_RESET;
      inner_cnt_r <= dmm_pkg::CNT_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        dmm_pkg::REG_ROW:   row_cnt_r   <= cfg_pwdata[dmm_pkg::CNT_W-1:0];
        dmm_pkg::REG_COL:   col_cnt_r   <= cfg_pwdata[dmm_pkg::CNT_W-1:0];
        dmm_pkg::REG_INNER: inner_cnt_r <= cfg_pwdata[dmm_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake and stores.
  logic in_xfer, load_ok, we_a, we_b;
  logic [AW-1:0] waddr, raddr_a, raddr_b;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer = in_ch.valid & in_ch.ready;
  assign load_ok = (EW'(in_ch.row_index) < MAXD) && (EW'(in_ch.col_index) < MAXD);
  assign we_a = in_xfer && load_ok && (in_ch.opcode == dmm_pkg::OP_LOAD_A);
  assign we_b = in_xfer && load_ok && (in_ch.opcode == dmm_pkg::OP_LOAD_B);
  assign waddr = AW'(in_ch.row_index) * AW'(MAX_DIM) + AW'(in_ch.col_index);
  assign raddr_a = AW'(row_r) * AW'(MAX_DIM) + AW'(i_r);
  assign raddr_b = AW'(i_r) * AW'(MAX_DIM) + AW'(j_r);

  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[waddr] <= in_ch.element_value;
    end
    rda_r <= mem_a[raddr_a];
  end

  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[waddr] <= in_ch.element_value;
    end
    rdb_r <= mem_b[raddr_b];
  end

  // Operand classification for the multiply-add step.
  logic sa, sb, sc, sp;
  logic a_zero, b_zero, c_zero, a_inf, b_inf, c_inf, any_nan, special;
  logic [31:0] spec_val;
  logic [47:0] prod;

  assign sa = rda_r[31];
  assign sb = rdb_r[31];
  assign sc = acc_r[31];
  assign sp = sa ^ sb;
  assign a_zero = (rda_r[30:0] == 31'd0);
  assign b_zero = (rdb_r[30:0] == 31'd0);
  assign c_zero = (acc_r[30:0] == 31'd0);
  assign a_inf = (rda_r[30:23] == 8'hFF) && (rda_r[22:0] == 23'd0);
  assign b_inf = (rdb_r[30:23] == 8'hFF) && (rdb_r[22:0] == 23'd0);
  assign c_inf = (acc_r[30:23] == 8'hFF) && (acc_r[22:0] == 23'd0);
  assign any_nan = ((rda_r[30:23] == 8'hFF) && (rda_r[22:0] != 23'd0)) ||
                   ((rdb_r[30:23] == 8'hFF) && (rdb_r[22:0] != 23'd0)) ||
                   ((acc_r[30:23] == 8'hFF) && (acc_r[22:0] != 23'd0));
  assign special = any_nan | a_inf | b_inf | c_inf | a_zero | b_zero;
  assign prod = 48'(dmm_pkg::sig_of(rda_r)) * 48'(dmm_pkg::sig_of(rdb_r));

  always_comb begin
    if (any_nan) begin
      spec_val = dmm_pkg::QNAN_BITS;
    end else if (a_inf | b_inf) begin
      if (a_zero | b_zero) begin
        spec_val = dmm_pkg::QNAN_BITS;
      end else if (c_inf && (sc != sp)) begin
        spec_val = dmm_pkg::QNAN_BITS;
      end else begin
        spec_val = {sp, dmm_pkg::INF_BITS[30:0]};
      end
    end else if (c_inf) begin
      spec_val = acc_r;
    end else if (c_zero) begin
      spec_val = {sp & sc, 31'd0};
    end else begin
      spec_val = acc_r;
    end
  end

  // Shared normalizing shifter: bit 62 is the target leading one.
  logic top_zero;
  logic [WW-1:0] w_step;
  logic signed [XW-1:0] e_step;
  assign top_zero = (w_r[62:55] == 8'd0);
  assign w_step = top_zero ? (w_r << 8) : (w_r << 1);
  assign e_step = top_zero ? (e_r - 12'sd8) : (e_r - 12'sd1);

  // Alignment of the smaller addend.
  logic signed [XW-1:0] ce_n, bexp, sexp;
  logic signed [XW:0]   dd;
  logic [WW-1:0]        cmn, bg, sm, sm_sh;
  logic                 p_big, bs;

  always_comb begin
    ce_n  = e_r + 12'sd1;
    cmn   = w_r >> 1;
    p_big = (pe_r > ce_n) || ((pe_r == ce_n) && (pm_r >= cmn));
    bg    = p_big ? pm_r : cmn;
    sm    = p_big ? cmn : pm_r;
    bexp  = p_big ? pe_r : ce_n;
    sexp  = p_big ? ce_n : pe_r;
    bs    = p_big ? sp_r : sc_r;
    dd    = (XW+1)'(bexp) - (XW+1)'(sexp);
    if (dd >= 13'sd64) begin
      sm_sh = 64'd1;
    end else begin
      sm_sh = (sm >> dd[5:0]) |
              {63'd0, |(sm & ((64'd1 << dd[5:0]) - 64'd1))};
    end
  end

  logic [WW-1:0] sum;
  assign sum = sub_r ? (big_r - small_r) : (big_r + small_r);

  // Rounding of the normalized result to binary32.
  logic signed [XW:0] ew, t0, shs, tt, t1, biased;
  logic [5:0]         shamt;
  logic               sh_big, gbit, stk;
  logic [WW-1:0]      mq;
  logic [24:0]        m25;
  logic [23:0]        m24;
  logic [31:0]        rnd_val;

  always_comb begin
    ew = (XW+1)'(e_r);
    t0 = ew + 13'sd39;
    if (t0 < -13'sd149) begin
      shs = -13'sd149 - ew;
    end else begin
      shs = 13'sd39;
    end
    tt     = ew + shs;
    sh_big = (shs >= 13'sd64);
    shamt  = shs[5:0];
    mq     = w_r >> shamt;
    gbit   = w_r[shamt - 6'd1];
    stk    = |(w_r & ((64'd1 << (shamt - 6'd1)) - 64'd1));
    m25    = sh_big ? 25'd0 : (mq[24:0] + 25'(gbit & (stk | mq[0])));
    if (m25[24]) begin
      m24 = 24'h80_0000;
      t1  = tt + 13'sd1;
    end else begin
      m24 = m25[23:0];
      t1  = tt;
    end
    biased = t1 + 13'sd150;
    if (!m24[23]) begin
      rnd_val = {bsign_r, 8'd0, m24[22:0]};
    end else if (biased >= 13'sd255) begin
      rnd_val = {bsign_r, dmm_pkg::INF_BITS[30:0]};
    end else begin
      rnd_val = {bsign_r, biased[7:0], m24[22:0]};
    end
  end

  // Sequencer.
  logic last_k, last_n;
  assign last_k = ((EW'(i_r) + EW'(1)) == k_eff);
  assign last_n = ((EW'(j_r) + EW'(1)) == n_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer && (in_ch.opcode == dmm_pkg::OP_COMPUTE) &&
              (EW'(in_ch.row_index) < m_eff)) begin
            row_r   <= in_ch.row_index;
            i_r     <= '0;
            j_r     <= '0;
            acc_r   <= '0;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (special) begin
            acc_r   <= spec_val;
            state_r <= S_NEXT;
          end else begin
            w_r     <= WW'(prod);
            e_r     <= dmm_pkg::unb_exp(rda_r[30:23]) + dmm_pkg::unb_exp(rdb_r[30:23]);
            sp_r    <= sp;
            sc_r    <= sc;
            cz_r    <= c_zero;
            cm_r    <= dmm_pkg::sig_of(acc_r);
            ce_r    <= dmm_pkg::unb_exp(acc_r[30:23]);
            state_r <= S_NPROD;
          end
        end
        S_NPROD: begin
          if (w_r[62]) begin
            pm_r <= w_r >> 1;
            pe_r <= e_r + 12'sd1;
            if (cz_r) begin
              bsign_r <= sp_r;
              state_r <= S_NRES;
            end else begin
              w_r     <= WW'(cm_r);
              e_r     <= ce_r;
              state_r <= S_NADD;
            end
          end else begin
            w_r <= w_step;
            e_r <= e_step;
          end
        end
        S_NADD: begin
          if (w_r[62]) begin
            state_r <= S_ALIGN;
          end else begin
            w_r <= w_step;
            e_r <= e_step;
          end
        end
        S_ALIGN: begin
          big_r   <= bg;
          small_r <= sm_sh;
          be_r    <= bexp;
          bsign_r <= bs;
          sub_r   <= sp_r ^ sc_r;
          state_r <= S_ADD;
        end
        S_ADD: begin
          if (sum == '0) begin
            acc_r   <= '0;
            state_r <= S_NEXT;
          end else begin
            w_r     <= sum;
            e_r     <= be_r;
            state_r <= S_NRES;
          end
        end
        S_NRES: begin
          if (w_r[62]) begin
            state_r <= S_ROUND;
          end else begin
            w_r <= w_step;
            e_r <= e_step;
          end
        end
        S_ROUND: begin
          acc_r   <= rnd_val;
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          if (last_k) begin
            out_row_r  <= row_r;
            out_col_r  <= dmm_pkg::IDX_W'(j_r);
            out_val_r  <= acc_r;
            out_done_r <= last_n;
            state_r    <= S_EMIT;
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_READ;
          end
        end
        S_EMIT: begin
          if (out_ch.ready) begin
            if (last_n) begin
              state_r <= S_IDLE;
            end else begin
              j_r     <= j_r + 1'b1;
              i_r     <= '0;
              acc_r   <= '0;
              state_r <= S_READ;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid         = (state_r == S_EMIT);
  assign out_ch.out_row       = out_row_r;
  assign out_ch.out_col       = out_col_r;
  assign out_ch.product_value = out_val_r;
  assign out_ch.row_done      = out_done_r;

endmodule
`default_nettype wire

/* verif/dmm_checker.sv */
`timescale 1ns / 1ps
module dmm_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  dmm_in_if                                  mon_in,
  dmm_out_if                                 mon_out,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic                               cfg_pready,
  input  logic [dmm_pkg::ADDR_W-1:0]         cfg_paddr,
  input  logic [dmm_pkg::DATA_W-1:0]         cfg_pwdata,
  output int                                 fail_count,
  output int                                 results_due
);
  import dmm_pkg::*;

  localparam int DIM = DEF_MAX_DIM;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             done;
  } c_elem_t;

  logic [VAL_W-1:0] left_store [DIM*DIM];
  logic [VAL_W-1:0] right_store[DIM*DIM];
  logic [CNT_W-1:0] row_cnt, col_cnt, inner_cnt;
  c_elem_t          c_elems_due[$];

  function automatic int clamp_dim(input logic [CNT_W-1:0] v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return v;
  endfunction

  function automatic int msb_at(input logic [63:0] v);
    int p;
    p = 0;
    while (v > 1) begin
      v = v >> 1;
      p++;
    end
    return p;
  endfunction

  function automatic logic [31:0] pack_rounded(input logic s, input logic [63:0] r,
                                               input int e);
    int t, sh;
    logic [63:0] m, rem, half;
    t = e + msb_at(r) - 23;
    if (t < -149) t = -149;
    sh = t - e;
    if (sh <= 0) begin
      m = r << (-sh);
    end else if (sh >= 64) begin
      m = 0;
    end else begin
      rem = r & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      m = r >> sh;
      if (rem > half || (rem == half && m[0])) m = m + 1;
    end
    if (m == (64'd1 << 24)) begin
      m = m >> 1;
      t++;
    end
    if (m >= (64'd1 << 23)) begin
      if (t + 150 >= 255) return {s, INF_BITS[30:0]};
      return {s, 8'(t + 150), m[22:0]};
    end
    return {s, m[30:0]};
  endfunction

  function automatic void to_top(inout logic [63:0] m, inout int e);
    while (!m[60]) begin
      m = m << 1;
      e--;
    end
  endfunction

  function automatic logic [31:0] fma_bits(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c);
    logic sa, sb, sc, sp, bsign;
    logic [7:0] xa, xb, xc;
    logic [22:0] fa, fb, fc;
    logic az, bz, cz;
    logic [63:0] pm, cm, big, lil, r, lost;
    int pe, ce, be, le, d;
    sa = a[31]; sb = b[31]; sc = c[31]; sp = sa ^ sb;
    xa = a[30:23]; xb = b[30:23]; xc = c[30:23];
    fa = a[22:0]; fb = b[22:0]; fc = c[22:0];
    az = (xa == 0 && fa == 0);
    bz = (xb == 0 && fb == 0);
    cz = (xc == 0 && fc == 0);
    if ((xa == 8'hFF && fa != 0) || (xb == 8'hFF && fb != 0) || (xc == 8'hFF && fc != 0))
      return QNAN_BITS;
    if (xa == 8'hFF || xb == 8'hFF) begin
      if (az || bz) return QNAN_BITS;
      if (xc == 8'hFF && sc != sp) return QNAN_BITS;
      return {sp, INF_BITS[30:0]};
    end
    if (xc == 8'hFF) return c;
    if (az || bz) begin
      if (cz) return {sp & sc, 31'd0};
      return c;
    end
    pm = 64'({xa != 0, fa}) * 64'({xb != 0, fb});
    pe = (xa != 0 ? int'(xa) - 150 : -149) + (xb != 0 ? int'(xb) - 150 : -149);
    to_top(pm, pe);
    if (cz) return pack_rounded(sp, pm, pe);
    cm = 64'({xc != 0, fc});
    ce = xc != 0 ? int'(xc) - 150 : -149;
    to_top(cm, ce);
    if (pe > ce || (pe == ce && pm >= cm)) begin
      big = pm; be = pe; bsign = sp; lil = cm; le = ce;
    end else begin
      big = cm; be = ce; bsign = sc; lil = pm; le = pe;
    end
    d = be - le;
    if (d >= 63) begin
      lil = 1;
    end else if (d > 0) begin
      lost = lil & ((64'd1 << d) - 1);
      lil = (lil >> d) | 64'(lost != 0);
    end
    if (sp == sc) begin
      r = big + lil;
    end else begin
      r = big - lil;
      if (r == 0) return 32'd0;
    end
    return pack_rounded(bsign, r, be);
  endfunction

  function automatic void predict_row(input logic [IDX_W-1:0] row);
    int n, k;
    logic [31:0] acc;
    c_elem_t e;
    n = clamp_dim(col_cnt);
    k = clamp_dim(inner_cnt);
    if (row >= clamp_dim(row_cnt)) return;
    for (int j = 0; j < n; j++) begin
      acc = 32'd0;
      for (int i = 0; i < k; i++)
        acc = fma_bits(left_store[row*DIM + i], right_store[i*DIM + j], acc);
      e.row = row;
      e.col = j[IDX_W-1:0];
      e.value = acc;
      e.done = (j + 1 == n);
      c_elems_due.push_back(e);
    end
  endfunction

  initial begin
    fail_count = 0;
    foreach (left_store[i]) left_store[i] = '0;
    foreach (right_store[i]) right_store[i] = '0;
  end

  always @(posedge clk) begin
    c_elem_t want;
    if (!rst_n) begin
      row_cnt = CNT_RESET;
      col_cnt = CNT_RESET;
      inner_cnt = CNT_RESET;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          REG_ROW: begin
            row_cnt = cfg_pwdata[CNT_W-1:0];
          end
          REG_COL: begin
            col_cnt = cfg_pwdata[CNT_W-1:0];
          end
          REG_INNER: begin
            inner_cnt = cfg_pwdata[CNT_W-1:0];
          end
          default: ;
        endcase
      end
      if (mon_out.valid && mon_out.ready) begin
        if (c_elems_due.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result transfer row %0d col %0d value %h done %b",
                   $time, mon_out.out_row, mon_out.out_col, mon_out.product_value,
                   mon_out.row_done);
        end else begin
          want = c_elems_due.pop_front();
          if (mon_out.out_row !== want.row || mon_out.out_col !== want.col ||
              mon_out.product_value !== want.value || mon_out.row_done !== want.done) begin
            fail_count++;
            $display("%0t: mismatch expected row %0d col %0d value %h done %b, %s",
                     $time, want.row, want.col, want.value, want.done,
                     $sformatf("actual row %0d col %0d value %h done %b",
                               mon_out.out_row, mon_out.out_col,
                               mon_out.product_value, mon_out.row_done));
          end
        end
      end
      if (mon_in.valid && mon_in.ready) begin
        case (mon_in.opcode)
          OP_LOAD_A: begin
            left_store[mon_in.row_index*DIM + mon_in.col_index] = mon_in.element_value;
          end
          OP_LOAD_B: begin
            right_store[mon_in.row_index*DIM + mon_in.col_index] = mon_in.element_value;
          end
          OP_COMPUTE: begin
            predict_row(mon_in.row_index);
          end
          default: ;
        endcase
      end
    end
    results_due = c_elems_due.size();
  end
endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import dmm_pkg::*;

  localparam int DIM = DEF_MAX_DIM;
  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata, cfg_prdata;
  int fail_count, results_due;
  int items_sent;
  bit hold_req;
  bit no_gaps;
  bit a_written[DIM*DIM];
  bit b_written[DIM*DIM];
  int m_eff, n_eff, k_eff;

  dmm_in_if in_ch();
  dmm_out_if out_ch();

  dense_matrix_multiply_unit u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  dmm_checker u_checker (
    .clk(clk), .rst_n(rst_n), .mon_in(in_ch), .mon_out(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .fail_count(fail_count), .results_due(results_due)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #200ms;
    $display("dense_matrix_multiply_unit regression: fail");
    $finish;
  end

  function automatic int clamp_dim(input int v);
    if (v == 0) return 1;
    if (v > DIM) return DIM;
    return v;
  endfunction

  function automatic logic [31:0] rand_float();
    logic [31:0] specials[12];
    specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'h807F_FFFF,
                 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h3F80_0000, 32'h0080_0000};
    case ($urandom_range(7))
      0, 1, 2, 3: return {1'($urandom), 8'($urandom_range(136, 118)), 23'($urandom)};
      4: return $urandom;
      5: return specials[$urandom_range(11)];
      6: return {1'($urandom), 8'($urandom_range(3)), 23'($urandom)};
      default: return {1'($urandom), 8'($urandom_range(254, 240)), 23'($urandom)};
    endcase
  endfunction

  task automatic send_item(input logic [OPC_W-1:0] op, input int row, input int col,
                           input logic [31:0] value);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.row_index <= row[IDX_W-1:0];
    in_ch.col_index <= col[IDX_W-1:0];
    in_ch.element_value <= value;
    do @(posedge clk); while (!in_ch.ready);
    if (op == OP_LOAD_A) a_written[row*DIM + col] = 1'b1;
    if (op == OP_LOAD_B) b_written[row*DIM + col] = 1'b1;
    if (op != OP_UNUSED) items_sent++;
    gap = 0;
    if (!no_gaps) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: gap = 0;
        6, 7, 8: gap = $urandom_range(3, 1);
        default: gap = $urandom_range(40, 10);
      endcase
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic compute_row(input int row);
    if (row < m_eff) begin
      for (int i = 0; i < k_eff; i++)
        if (!a_written[row*DIM + i]) send_item(OP_LOAD_A, row, i, rand_float());
      for (int i = 0; i < k_eff; i++)
        for (int j = 0; j < n_eff; j++)
          if (!b_written[i*DIM + j]) send_item(OP_LOAD_B, i, j, rand_float());
    end
    send_item(OP_COMPUTE, row, $urandom_range(63), $urandom);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_W'({idx, 2'b00});
    cfg_pwdata <= DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_dims(input int rows, input int cols, input int inner);
    drain();
    write_reg(REG_ROW, rows);
    write_reg(REG_COL, cols);
    write_reg(REG_INNER, inner);
    m_eff = clamp_dim(rows);
    n_eff = clamp_dim(cols);
    k_eff = clamp_dim(inner);
  endtask

  task automatic random_phase(input int count);
    int pick;
    for (int t = 0; t < count && items_sent < 350; t++) begin
      pick = $urandom_range(19);
      if (pick < 9) begin
        send_item(pick[0] ? OP_LOAD_B : OP_LOAD_A, $urandom_range(63), $urandom_range(63),
                  rand_float());
      end else if (pick < 16) begin
        compute_row($urandom_range(m_eff - 1));
      end else if (pick < 18) begin
        compute_row($urandom_range(63));
      end else begin
        send_item(OP_UNUSED, $urandom_range(63), $urandom_range(63), $urandom);
      end
    end
  endtask

  initial begin
    int pick, r, c, k;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= OP_LOAD_A;
    in_ch.row_index <= '0;
    in_ch.col_index <= '0;
    in_ch.element_value <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    items_sent = 0;
    hold_req = 1'b0;
    no_gaps = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_dims(4, 4, 4);
    send_item(OP_LOAD_A, 0, 0, 32'h7F80_0000);
    send_item(OP_LOAD_A, 0, 1, 32'h3F80_0000);
    send_item(OP_LOAD_A, 0, 2, 32'h0000_0001);
    send_item(OP_LOAD_A, 0, 3, 32'h7F7F_FFFF);
    send_item(OP_LOAD_B, 0, 0, 32'h0000_0000);
    send_item(OP_LOAD_B, 0, 1, 32'h3F80_0000);
    send_item(OP_LOAD_B, 0, 2, 32'hFF80_0000);
    send_item(OP_LOAD_B, 0, 3, 32'h7FC0_0001);
    compute_row(0);
    send_item(OP_LOAD_A, 1, 0, 32'h3F80_0000);
    send_item(OP_LOAD_A, 1, 1, 32'h3F80_0000);
    send_item(OP_LOAD_A, 1, 2, 32'h8000_0000);
    send_item(OP_LOAD_A, 1, 3, 32'h807F_FFFF);
    send_item(OP_LOAD_B, 1, 0, 32'hBF80_0000);
    send_item(OP_LOAD_B, 1, 1, 32'h7F7F_FFFF);
    send_item(OP_LOAD_B, 2, 0, 32'h8000_0000);
    compute_row(1);
    send_item(OP_LOAD_A, 2, 0, 32'h8000_0000);
    compute_row(2);
    send_item(OP_LOAD_A, 63, 63, 32'hFFFF_FFFF);
    send_item(OP_LOAD_B, 63, 63, 32'h0080_0000);
    compute_row(63);
    send_item(OP_UNUSED, 63, 63, 32'hFFFF_FFFF);
    compute_row(3);

    set_dims(64, 64, 1);
    compute_row(63);
    set_dims(1, 1, 64);
    compute_row(0);
    set_dims(0, 127, 0);
    compute_row(0);
    compute_row(1);

    set_dims(6, 3, 5);
    hold_req = 1'b1;
    for (int t = 0; t < 8; t++) compute_row($urandom_range(5));

    while (items_sent < 350) begin
      pick = $urandom_range(7);
      r = $urandom_range(64, 1);
      if (pick == 0) begin
        c = 64; k = 1;
      end else if (pick == 1) begin
        c = 1; k = 64;
      end else if (pick == 2) begin
        c = $urandom_range(1) ? 0 : 127;
        k = $urandom_range(1) ? 0 : 127;
        if (c == 127 && k == 127) k = 1;
      end else begin
        c = $urandom_range(8, 1); k = $urandom_range(8, 1);
      end
      set_dims(r, c, k);
      no_gaps = ($urandom_range(3) == 0);
      random_phase($urandom_range(40, 15));
    end

    no_gaps = 1'b0;
    in_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("dense_matrix_multiply_unit regression: pass");
    end else begin
      $display("dense_matrix_multiply_unit regression: fail");
    end
    $finish;
  end

  initial begin
    int stall, run;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (600) @(posedge clk);
      end else begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5: stall = 1;
          6, 7, 8: stall = $urandom_range(4, 2);
          default: stall = $urandom_range(60, 15);
        endcase
        run = ($urandom_range(7) == 0) ? $urandom_range(300, 100) : $urandom_range(6, 1);
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat (run) @(posedge clk);
    end
  end
endmodule

/* files.f */
rtl/core/dmm_pkg.sv
rtl/core/dmm_if.sv
rtl/core/dense_matrix_multiply_unit.sv
verif/dmm_checker.sv
verif/tb_top.sv
